FILE: sv/mtsfp_pkg.sv
// mtsfp_pkg: word types, item kind codes and framing constants for the
// serial frame parser. No dependencies; imported by every module of the block.
package mtsfp_pkg;

	// received byte word
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} in_word_t;

	// parsed item word
	typedef struct packed {
		logic [1:0]  item_kind;
		logic [15:0] command_id;
		logic [7:0]  pay_len;
		logic [7:0]  data_byte;
		logic        check_ok;
		logic        frame_last;
	} out_word_t;

	// items produced by one received byte (at most two)
	typedef struct packed {
		logic [1:0] cnt;
		out_word_t  item0;
		out_word_t  item1;
	} push_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ABORT  = 2'd3;

	localparam logic [7:0] START_BYTE     = 8'hFE;
	localparam logic [7:0] MAX_LEN_RESET  = 8'd250;

endpackage

FILE: sv/mtsfp_parse.sv
// mtsfp_parse: framing state machine, check accumulator and the length limit
// register. Turns each accepted byte into zero, one or two items.
// Depends on mtsfp_pkg.
module mtsfp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mtsfp_pkg::in_word_t in_word,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	output mtsfp_pkg::push_t   push
);
	import mtsfp_pkg::*;

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_CMD0  = 3'd2;
	localparam logic [2:0] PH_CMD1  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;

	logic [2:0] phase_q, phase_nxt;
	logic [7:0] len_q, len_nxt;
	logic [7:0] left_q, left_nxt;
	logic [7:0] cmd0_q, cmd0_nxt;
	logic [7:0] acc_q, acc_nxt;
	logic [7:0] max_len_q;
	logic       in_frame;
	logic [7:0] b;

	assign b = in_word.rx_byte;

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// next state and items for the incoming byte
	always_comb begin
		phase_nxt = phase_q;
		len_nxt   = len_q;
		left_nxt  = left_q;
		cmd0_nxt  = cmd0_q;
		acc_nxt   = acc_q;
		in_frame  = 1'b0;
		push      = '0;
		case (phase_q)
			PH_LEN: begin
				len_nxt   = b;
				acc_nxt   = b;
				phase_nxt = PH_CMD0;
			end
			PH_CMD0: begin
				cmd0_nxt  = b;
				acc_nxt   = acc_q ^ b;
				phase_nxt = PH_CMD1;
			end
			PH_CMD1: begin
				acc_nxt = acc_q ^ b;
				if (len_q > max_len_q) begin
					phase_nxt = PH_HUNT;
				end else begin
					push.cnt              = 2'd1;
					push.item0.item_kind  = KIND_HEADER;
					push.item0.command_id = {cmd0_q, b};
					push.item0.pay_len    = len_q;
					left_nxt              = len_q;
					phase_nxt             = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
					in_frame              = 1'b1;
				end
			end
			PH_DATA: begin
				acc_nxt               = acc_q ^ b;
				push.cnt              = 2'd1;
				push.item0.item_kind  = KIND_DATA;
				push.item0.data_byte  = b;
				left_nxt              = left_q - 8'd1;
				if (left_nxt == 8'd0) begin
					phase_nxt = PH_CHECK;
				end
				in_frame = 1'b1;
			end
			PH_CHECK: begin
				push.cnt              = 2'd1;
				push.item0.item_kind  = KIND_END;
				push.item0.check_ok   = (b == acc_q);
				push.item0.frame_last = 1'b1;
				phase_nxt             = PH_HUNT;
			end
			default: begin
				phase_nxt = (b == START_BYTE) ? PH_LEN : PH_HUNT;
			end
		endcase
		// chunk end drops a partial frame, with an abort once the header is out
		if (in_word.chunk_end && (phase_nxt != PH_HUNT)) begin
			if (in_frame) begin
				push.cnt              = 2'd2;
				push.item1.item_kind  = KIND_ABORT;
				push.item1.frame_last = 1'b1;
			end
			phase_nxt = PH_HUNT;
		end
		if (!accept) begin
			push.cnt = 2'd0;
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			left_q  <= '0;
			cmd0_q  <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			len_q   <= len_nxt;
			left_q  <= left_nxt;
			cmd0_q  <= cmd0_nxt;
			acc_q   <= acc_nxt;
		end
	end

endmodule

FILE: sv/mtsfp_outq.sv
// mtsfp_outq: small result queue that takes up to two items per cycle and
// hands out one per cycle while out_stall is low. Depends on mtsfp_pkg.
module mtsfp_outq #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtsfp_pkg::push_t     push,
	output logic                 full2,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mtsfp_pkg::out_word_t out_word
);
	import mtsfp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

	out_word_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW-1:0]   wr_ptr_p1, wr_ptr_p2, rd_ptr_p1;
	logic [CW-1:0]   count_q;
	logic            pop;

	// wrapped pointer increments
	assign wr_ptr_p1 = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
	assign wr_ptr_p2 = (wr_ptr_p1 == LAST_PTR) ? '0 : wr_ptr_p1 + PW'(1);
	assign rd_ptr_p1 = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);

	assign out_valid = (count_q != '0);
	assign out_word  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	// room for two more words is needed before the next byte is taken
	assign full2     = (count_q > ROOM_LIMIT);

	// entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push.item0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.item1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.cnt)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

FILE: sv/mt_serial_frame_parser.sv
// mt_serial_frame_parser: receive-side framing of a serial command stream.
// Depends on mtsfp_pkg, mtsfp_parse and mtsfp_outq.
//
// Usage: bytes enter on the in channel (in_valid / in_stall / in_word), one
// word per byte with its chunk_end flag. Parsed items leave on the out channel
// (out_valid / out_stall / out_word): a header with command id and length,
// one word per payload byte, then a frame end carrying check_ok, or an abort
// when a chunk ends inside a frame. Bytes before a start byte, oversized
// frames and frames cut off before their header produce nothing.
// Items are registered in the output queue and leave in order. Throughput:
// one byte per cycle while in_stall is low; a byte that yields two items (a
// payload or header byte with chunk_end) queues both, which leave one at a
// time. The rate is set by the output queue, which holds OUT_DEPTH words and
// takes a byte only while room for two words remains.
// Reset: the parser returns to hunting for a start byte, the queue empties
// and the length limit returns to 250. cfg_wr_en writes the limit; write it
// only while no frame is in progress. When the receiver stalls, the queue
// fills and in_stall rises; no item is lost or repeated.
module mt_serial_frame_parser #(
	parameter int OUT_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mtsfp_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mtsfp_pkg::out_word_t out_word,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data
);
	import mtsfp_pkg::*;

	push_t push;
	logic  accept;
	logic  full2;

	assign in_stall = full2;
	assign accept   = in_valid && !in_stall;

	// framing state machine
	mtsfp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_word    (in_word),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push)
	);

	// result queue
	mtsfp_outq #(
		.DEPTH(OUT_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full2    (full2),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

FILE: sv/mtsfp_check.sv
// mtsfp_check: port-level checks on the item stream of the serial frame
// parser, bound to the top level. Depends on mtsfp_pkg.
module mtsfp_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input mtsfp_pkg::out_word_t out_word
);
	import mtsfp_pkg::*;

	// frame_last marks exactly the end and abort items
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.frame_last ==
			((out_word.item_kind == KIND_END) || (out_word.item_kind == KIND_ABORT))))
		else $error("frame_last does not match item kind");

	// header fields are zero outside headers
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_word.item_kind != KIND_HEADER)) |->
			((out_word.command_id == 16'd0) && (out_word.pay_len == 8'd0)))
		else $error("header fields set on non-header item");

	// check_ok only on frame end, data_byte only on payload items
	a_ok_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.item_kind == KIND_END) || !out_word.check_ok) &&
			((out_word.item_kind == KIND_DATA) || (out_word.data_byte == 8'd0)))
		else $error("field set outside its item kind");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("stalled output word changed");

endmodule

bind mt_serial_frame_parser mtsfp_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

FILE: bench/mt_serial_frame_parser_test.sv
// mt_serial_frame_parser_test: self-checking bench for the serial frame parser.
// Drives received bytes, predicts parsed items and checks every item word.
// Depends on mtsfp_pkg and mt_serial_frame_parser.
`timescale 1ns / 100ps

module mt_serial_frame_parser_test;
	import mtsfp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int SEG_WORDS    = 130;
	localparam out_word_t NONE  = '0;

	typedef enum logic [2:0] {
		SEEK, GET_LEN, GET_CMD0, GET_CMD1, GET_DATA, GET_CHECK
	} parse_phase_t;

	// one row of the directed byte table
	typedef struct packed {
		in_word_t   w;
		logic       has_want;
		logic [1:0] want_cnt;
		out_word_t  want0;
		out_word_t  want1;
	} byte_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	// predictor state
	parse_phase_t phase_q = SEEK;
	logic [7:0]   frame_len = '0;
	logic [7:0]   bytes_left = '0;
	logic [7:0]   cmd_hi = '0;
	logic [7:0]   xor_sum = '0;
	logic [7:0]   len_limit = MAX_LEN_RESET;

	out_word_t step_items[$];
	out_word_t expected_items[$];
	in_word_t  plan_q[$];
	byte_row_t byte_table[$];

	int   error_count = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 27;
	int   recv_idle_pct = 54;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	mt_serial_frame_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items pending", cycle_count,
				expected_items.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_items(input string where, input out_word_t got,
		input out_word_t want);
		if (got.item_kind !== want.item_kind)
			flag_error($sformatf("%s item_kind %0d want %0d", where, got.item_kind,
				want.item_kind));
		if (got.command_id !== want.command_id)
			flag_error($sformatf("%s command_id %h want %h", where, got.command_id,
				want.command_id));
		if (got.pay_len !== want.pay_len)
			flag_error($sformatf("%s pay_len %0d want %0d", where,
				got.pay_len, want.pay_len));
		if (got.data_byte !== want.data_byte)
			flag_error($sformatf("%s data_byte %h want %h", where, got.data_byte,
				want.data_byte));
		if (got.check_ok !== want.check_ok)
			flag_error($sformatf("%s check_ok %b want %b", where, got.check_ok,
				want.check_ok));
		if (got.frame_last !== want.frame_last)
			flag_error($sformatf("%s frame_last %b want %b", where, got.frame_last,
				want.frame_last));
	endtask

	function automatic out_word_t item_of(input logic [1:0] kind, input logic [15:0] cmd,
		input logic [7:0] len, input logic [7:0] data, input logic ok, input logic last);
		out_word_t o;
		o.item_kind = kind;
		o.command_id = cmd;
		o.pay_len = len;
		o.data_byte = data;
		o.check_ok = ok;
		o.frame_last = last;
		return o;
	endfunction

	function automatic in_word_t word_of(input logic [7:0] b, input logic ce);
		in_word_t w;
		w.rx_byte = b;
		w.chunk_end = ce;
		return w;
	endfunction

	// frame parser prediction for one accepted byte, items into step_items
	function automatic void predict_frame_items(input in_word_t w);
		logic in_frame;
		logic [7:0] b;
		in_frame = 1'b0;
		b = w.rx_byte;
		step_items.delete();
		case (phase_q)
			GET_LEN: begin
				frame_len = b;
				xor_sum = b;
				phase_q = GET_CMD0;
			end
			GET_CMD0: begin
				cmd_hi = b;
				xor_sum = xor_sum ^ b;
				phase_q = GET_CMD1;
			end
			GET_CMD1: begin
				xor_sum = xor_sum ^ b;
				if (frame_len > len_limit) begin
					phase_q = SEEK;
				end else begin
					step_items = {step_items, item_of(KIND_HEADER, {cmd_hi, b},
						frame_len, 8'h00, 1'b0, 1'b0)};
					bytes_left = frame_len;
					if (frame_len == 8'd0)
						phase_q = GET_CHECK;
					else
						phase_q = GET_DATA;
					in_frame = 1'b1;
				end
			end
			GET_DATA: begin
				xor_sum = xor_sum ^ b;
				step_items = {step_items,
					item_of(KIND_DATA, 16'h0, 8'h00, b, 1'b0, 1'b0)};
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0)
					phase_q = GET_CHECK;
				in_frame = 1'b1;
			end
			GET_CHECK: begin
				step_items = {step_items, item_of(KIND_END, 16'h0, 8'h00, 8'h00,
					b == xor_sum, 1'b1)};
				phase_q = SEEK;
			end
			default: begin
				if (b == START_BYTE)
					phase_q = GET_LEN;
				else
					phase_q = SEEK;
			end
		endcase
		// chunk end drops a partial frame, aborting it once its header is out
		if (w.chunk_end && phase_q != SEEK) begin
			if (in_frame)
				step_items = {step_items,
					item_of(KIND_ABORT, 16'h0, 8'h00, 8'h00, 1'b0, 1'b1)};
			phase_q = SEEK;
		end
	endfunction

	// random frame with noise, bad checks and chunk cuts; returns frame words
	function automatic int plan_frame(input logic [7:0] lim);
		int len;
		int pick;
		int cut;
		logic [7:0] b;
		logic [7:0] acc;
		logic [7:0] c0;
		logic [7:0] c1;
		in_word_t fw[$];
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// stray bytes and broken pieces, start byte included
			repeat ($urandom_range(1, 5)) begin
				b = ($urandom_range(0, 2) == 0) ? START_BYTE : 8'($urandom);
				plan_q = {plan_q, word_of(b, $urandom_range(0, 3) == 0)};
			end
			return 0;
		end
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom);
			if (b == START_BYTE)
				b = 8'h00;
			plan_q = {plan_q, word_of(b, 1'b0)};
		end
		pick = $urandom_range(0, 99);
		if (pick < 6 && lim != 8'hFF)
			len = $urandom_range(int'(lim) + 1, 255);
		else if (pick < 8)
			len = int'(lim);
		else if (pick < 10)
			len = $urandom_range(0, int'(lim));
		else
			len = $urandom_range(0, (lim < 8'd12) ? int'(lim) : 12);
		c0 = 8'($urandom);
		c1 = 8'($urandom);
		acc = 8'(len) ^ c0 ^ c1;
		fw = {fw, word_of(START_BYTE, 1'b0)};
		fw = {fw, word_of(8'(len), 1'b0)};
		fw = {fw, word_of(c0, 1'b0)};
		fw = {fw, word_of(c1, 1'b0)};
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			acc = acc ^ b;
			fw = {fw, word_of(b, 1'b0)};
		end
		if ($urandom_range(0, 99) < 85)
			fw = {fw, word_of(acc, 1'b0)};
		else
			fw = {fw, word_of(acc ^ 8'($urandom_range(1, 255)), 1'b0)};
		// cut the frame short, or end the chunk on its check byte
		pick = $urandom_range(0, 99);
		if (pick < 8)
			cut = $urandom_range(0, fw.size() - 1);
		else
			cut = fw.size() - 1;
		if (pick < 38)
			fw[cut].chunk_end = 1'b1;
		for (int i = 0; i <= cut; i++)
			plan_q = {plan_q, fw[i]};
		return cut + 1;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic ce, input logic has,
		input logic [1:0] cnt, input out_word_t w0, input out_word_t w1);
		byte_row_t r;
		r.w = word_of(b, ce);
		r.has_want = has;
		r.want_cnt = cnt;
		r.want0 = w0;
		r.want1 = w1;
		byte_table = {byte_table, r};
	endtask

	// offer one word, hold it until taken, then predict its items
	task automatic send_word(input in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_frame_items(w);
		foreach (step_items[i])
			expected_items = {expected_items, step_items[i]};
	endtask

	task automatic wait_drained();
		while (expected_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		len_limit = v;
	endtask

	task automatic run_segment(input logic [7:0] lim, input int s_idle, input int r_idle,
		input logic hold);
		wait_drained();
		write_limit(lim);
		send_idle_pct = s_idle;
		recv_idle_pct <= r_idle;
		if (hold)
			hold_toggle <= ~hold_toggle;
		while (plan_q.size() < SEG_WORDS)
			void'(plan_frame(lim));
		while (plan_q.size() != 0)
			send_word(plan_q.pop_front());
		// back to hunting before the next limit write
		send_word(word_of(8'h00, 1'b1));
		in_valid <= 1'b0;
	endtask

	// receiver: random stall, long hold-off on request, item checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_items.size() == 0)
				flag_error($sformatf("unexpected item kind %0d", out_word.item_kind));
			else
				compare_items("out", out_word, expected_items.pop_front());
		end
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;

		// directed table: reset limit, extremes, bad check, skip and chunk cuts
		add_row(8'h00, 1'b0, 1'b1, 2'd0, NONE, NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'hFF, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b0, 1'b1, 2'd1,
			item_of(KIND_HEADER, 16'hFF00, 8'd0, 8'h00, 1'b0, 1'b0), NONE);
		add_row(8'hFF, 1'b1, 1'b1, 2'd1,
			item_of(KIND_END, 16'h0, 8'd0, 8'h00, 1'b1, 1'b1), NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h02, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h12, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h34, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b0, 1'b1, 2'd1,
			item_of(KIND_END, 16'h0, 8'd0, 8'h00, 1'b0, 1'b1), NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'hFB, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h01, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h02, 1'b1, 1'b1, 2'd0, NONE, NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'hAB, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'hCD, 1'b1, 1'b1, 2'd2,
			item_of(KIND_HEADER, 16'hABCD, 8'd0, 8'h00, 1'b0, 1'b0),
			item_of(KIND_ABORT, 16'h0, 8'd0, 8'h00, 1'b0, 1'b1));
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h01, 1'b1, 1'b1, 2'd0, NONE, NONE);
		add_row(8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h03, 1'b0, 1'b0, 2'd0, NONE, NONE);
		add_row(8'h00, 1'b1, 1'b1, 2'd0, NONE, NONE);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table; typed rows also cross-check the predictor
		foreach (byte_table[i]) begin
			send_word(byte_table[i].w);
			if (byte_table[i].has_want) begin
				if (step_items.size() != byte_table[i].want_cnt)
					flag_error($sformatf("row %0d gives %0d items, want %0d", i,
						step_items.size(), byte_table[i].want_cnt));
				else begin
					if (step_items.size() > 0)
						compare_items($sformatf("row %0d", i), step_items[0],
							byte_table[i].want0);
					if (step_items.size() > 1)
						compare_items($sformatf("row %0d", i), step_items[1],
							byte_table[i].want1);
				end
			end
		end
		in_valid <= 1'b0;

		// random frames over several limits and idling mixes
		run_segment(8'd255, 27, 54, 1'b1);
		run_segment(8'd0, 27, 54, 1'b0);
		run_segment(8'($urandom_range(1, 254)), 54, 27, 1'b0);
		run_segment(MAX_LEN_RESET, 54, 27, 1'b0);
		run_segment(8'd16, 0, 0, 1'b0);
		run_segment(8'd255, 0, 0, 1'b0);

		wait_drained();
		if (expected_items.size() != 0)
			flag_error($sformatf("%0d items never arrived", expected_items.size()));
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/mtsfp_pkg.sv
sv/mtsfp_parse.sv
sv/mtsfp_outq.sv
sv/mt_serial_frame_parser.sv
sv/mtsfp_check.sv
bench/mt_serial_frame_parser_test.sv
